// ===== rtl/frame_luma_exposure_check_unit_defines.svh =====
// assertion macros shared by flec_pixel.sv and flec_seq.sv
`ifndef FRAME_LUMA_EXPOSURE_CHECK_UNIT_DEFINES_SVH
`define FRAME_LUMA_EXPOSURE_CHECK_UNIT_DEFINES_SVH

// condition holds at every clock edge out of reset
`define FLEC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define FLEC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/flec_pkg.sv =====
package flec_pkg;

    localparam int DIM_W      = 14;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int PIX_W      = 8;
    localparam int CNT_W      = 27;
    localparam int LUMA_W     = 24;
    localparam int LUMA_SUM_W = 50;
    localparam int CH_SUM_W   = 34;
    localparam int MEAN_W     = 8;
    localparam int Q_FRAC     = 16;
    localparam int SHI_W      = LUMA_SUM_W - Q_FRAC;

    localparam int MA_W = 14;
    localparam int MB_W = 34;
    localparam int MP_W = MA_W + MB_W;

    localparam int MAX_DIMENSION_DEF = 8192;
    localparam longint unsigned CAP_LIMIT = 64'd67108864;

    localparam logic [LUMA_W-1:0] W_RED   = 24'd13933;
    localparam logic [LUMA_W-1:0] W_GREEN = 24'd46871;
    localparam logic [LUMA_W-1:0] W_BLUE  = 24'd4732;

    localparam logic [LUMA_W-1:0] DARK_LIMIT   = 24'd786432;
    localparam logic [LUMA_W-1:0] BRIGHT_LIMIT = 24'd16056320;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_CITY     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAP      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INTERIOR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_WARDROBE = 2'd3;

    typedef struct packed {
        logic [LUMA_SUM_W-1:0] luma_sum;
        logic [CH_SUM_W-1:0]   red_sum;
        logic [CH_SUM_W-1:0]   blue_sum;
        logic [CNT_W-1:0]      dark;
        logic [CNT_W-1:0]      bright;
        logic [CNT_W-1:0]      count;
        logic                  overflow;
    } acc_t;

    typedef struct packed {
        logic [MP_W-1:0] lhs;
        logic [MA_W-1:0] mul_a;
        logic [MB_W-1:0] mul_b;
    } mcu_op_t;

    typedef struct packed {
        logic            ge;
        logic            eq;
        logic [MP_W-1:0] diff;
        logic [MP_W-1:0] prod;
    } mcu_res_t;

    function automatic logic [7:0] mean_low(input logic [MODE_W-1:0] mode);
        logic [7:0] v;
        case (mode)
            MODE_MAP:      v = 8'd12;
            MODE_INTERIOR: v = 8'd25;
            MODE_WARDROBE: v = 8'd45;
            default:       v = 8'd95;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] mean_high(input logic [MODE_W-1:0] mode);
        logic [7:0] v;
        case (mode)
            MODE_MAP:      v = 8'd110;
            MODE_INTERIOR: v = 8'd160;
            MODE_WARDROBE: v = 8'd170;
            default:       v = 8'd145;
        endcase
        return v;
    endfunction

    function automatic logic [6:0] crush_pct(input logic [MODE_W-1:0] mode);
        logic [6:0] v;
        case (mode)
            MODE_MAP:      v = 7'd90;
            MODE_INTERIOR: v = 7'd50;
            MODE_WARDROBE: v = 7'd35;
            default:       v = 7'd12;
        endcase
        return v;
    endfunction

    function automatic logic [6:0] clip_pct(input logic [MODE_W-1:0] mode);
        logic [6:0] v;
        case (mode)
            MODE_INTERIOR: v = 7'd5;
            MODE_WARDROBE: v = 7'd5;
            default:       v = 7'd3;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/frame_luma_exposure_check_unit.sv =====
// channel   direction  handshake              payload
// pixel     in         in_valid / in_ready    pixel_red, pixel_green, pixel_blue, frame_last
// result    out        out_valid / out_ready  frame_passed, size_error, luma_average,
//                                             crushed_pixels, clipped_pixels, pixels_seen
// config    in         cfg_wr_en              cfg_index, cfg_data
//
// pixels without frame_last are taken one per cycle through a two stage luma/accumulate pipe
// a frame_last pixel holds in_ready low while the frame is judged: a drain state, 18 operations
// on the shared multiply-compare unit (8 division steps, 10 limit check and scale steps)
// and the load of the result register; the accumulators clear as it loads
// the load waits, with in_ready low, while the previous result has not been taken
// asynchronous active-low reset clears config, accumulators and control
module frame_luma_exposure_check_unit
    import flec_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PIX_W-1:0]     pixel_red,
    input  logic [PIX_W-1:0]     pixel_green,
    input  logic [PIX_W-1:0]     pixel_blue,
    input  logic                 frame_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 frame_passed,
    output logic                 size_error,
    output logic [MEAN_W-1:0]    luma_average,
    output logic [CNT_W-1:0]     crushed_pixels,
    output logic [CNT_W-1:0]     clipped_pixels,
    output logic [CNT_W-1:0]     pixels_seen,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    logic     pixel_take;
    logic     acc_clear;
    acc_t     acc;
    mcu_op_t  mcu_op;
    mcu_res_t mcu_res;

    assign pixel_take = in_valid && in_ready;

    flec_pixel #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_pixel (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_take  (pixel_take),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .acc_clear   (acc_clear),
        .acc         (acc)
    );

    flec_mcu u_mcu (
        .clk (clk),
        .op  (mcu_op),
        .res (mcu_res)
    );

    flec_seq #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel_take     (pixel_take),
        .frame_last     (frame_last),
        .in_ready       (in_ready),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .acc            (acc),
        .acc_clear      (acc_clear),
        .mcu_op         (mcu_op),
        .mcu_res        (mcu_res),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_passed   (frame_passed),
        .size_error     (size_error),
        .luma_average   (luma_average),
        .crushed_pixels (crushed_pixels),
        .clipped_pixels (clipped_pixels),
        .pixels_seen    (pixels_seen)
    );

endmodule

// ===== rtl/flec_mcu.sv =====
module flec_mcu
    import flec_pkg::*;
(
    input  logic     clk,
    input  mcu_op_t  op,
    output mcu_res_t res
);

    logic [MP_W-1:0] prod_reg;
    logic [MP_W-1:0] prod_next;
    logic [MP_W-1:0] lhs_reg;

    assign prod_next = MP_W'(op.mul_a) * MP_W'(op.mul_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        lhs_reg  <= op.lhs;
    end

    assign res.ge   = lhs_reg >= prod_reg;
    assign res.eq   = lhs_reg == prod_reg;
    assign res.diff = lhs_reg - prod_reg;
    assign res.prod = prod_reg;

endmodule

// ===== rtl/flec_pixel.sv =====
`include "frame_luma_exposure_check_unit_defines.svh"

module flec_pixel
    import flec_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_take,
    input  logic [PIX_W-1:0] pixel_red,
    input  logic [PIX_W-1:0] pixel_green,
    input  logic [PIX_W-1:0] pixel_blue,
    input  logic             acc_clear,
    output acc_t             acc
);

    localparam longint unsigned DimSq  = longint'(MAX_DIMENSION) * longint'(MAX_DIMENSION);
    localparam longint unsigned CapAll = (DimSq > CAP_LIMIT) ? CAP_LIMIT : DimSq;
    localparam logic [CNT_W-1:0] CountCap = CNT_W'(CapAll);

    logic [LUMA_W-1:0] luma_next;
    logic [LUMA_W-1:0] luma_reg;
    logic [PIX_W-1:0]  red_reg;
    logic [PIX_W-1:0]  blue_reg;
    logic              stage_valid_reg;

    logic [LUMA_SUM_W-1:0] luma_sum_reg;
    logic [CH_SUM_W-1:0]   red_sum_reg;
    logic [CH_SUM_W-1:0]   blue_sum_reg;
    logic [CNT_W-1:0]      dark_reg;
    logic [CNT_W-1:0]      bright_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  overflow_reg;

    // luma in q16, constant weights
    assign luma_next = W_RED * LUMA_W'(pixel_red)
                     + W_GREEN * LUMA_W'(pixel_green)
                     + W_BLUE * LUMA_W'(pixel_blue);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= pixel_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_take)
        begin
            luma_reg <= luma_next;
            red_reg  <= pixel_red;
            blue_reg <= pixel_blue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_sum_reg <= '0;
            red_sum_reg  <= '0;
            blue_sum_reg <= '0;
            dark_reg     <= '0;
            bright_reg   <= '0;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (acc_clear)
        begin
            luma_sum_reg <= '0;
            red_sum_reg  <= '0;
            blue_sum_reg <= '0;
            dark_reg     <= '0;
            bright_reg   <= '0;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (stage_valid_reg)
        begin
            if (count_reg >= CountCap)
            begin
                overflow_reg <= 1'b1;
            end
            else
            begin
                luma_sum_reg <= luma_sum_reg + LUMA_SUM_W'(luma_reg);
                red_sum_reg  <= red_sum_reg + CH_SUM_W'(red_reg);
                blue_sum_reg <= blue_sum_reg + CH_SUM_W'(blue_reg);
                if (luma_reg < DARK_LIMIT)
                begin
                    dark_reg <= dark_reg + 1'b1;
                end
                if (luma_reg > BRIGHT_LIMIT)
                begin
                    bright_reg <= bright_reg + 1'b1;
                end
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    assign acc.luma_sum = luma_sum_reg;
    assign acc.red_sum  = red_sum_reg;
    assign acc.blue_sum = blue_sum_reg;
    assign acc.dark     = dark_reg;
    assign acc.bright   = bright_reg;
    assign acc.count    = count_reg;
    assign acc.overflow = overflow_reg;

    `FLEC_ASSERT_ALWAYS(a_count_cap, count_reg <= CountCap, "pixel count above cap")
    `FLEC_ASSERT_IMPLY(a_overflow_at_cap, overflow_reg, count_reg == CountCap, "overflow below cap")
    `FLEC_ASSERT_IMPLY(a_clear_idle, acc_clear, !stage_valid_reg, "clear with pixel in flight")

endmodule

// ===== rtl/flec_seq.sv =====
`include "frame_luma_exposure_check_unit_defines.svh"

module flec_seq
    import flec_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_take,
    input  logic                 frame_last,
    output logic                 in_ready,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  acc_t                 acc,
    output logic                 acc_clear,
    output mcu_op_t              mcu_op,
    input  mcu_res_t             mcu_res,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 frame_passed,
    output logic                 size_error,
    output logic [MEAN_W-1:0]    luma_average,
    output logic [CNT_W-1:0]     crushed_pixels,
    output logic [CNT_W-1:0]     clipped_pixels,
    output logic [CNT_W-1:0]     pixels_seen
);

    localparam logic [DIM_W:0] MaxDim  = (DIM_W + 1)'(MAX_DIMENSION);
    localparam int             SCALE_W = 37;

    localparam logic [4:0] OP_DIV_FIRST    = 5'd0;
    localparam logic [4:0] OP_DIV_LAST     = 5'd7;
    localparam logic [4:0] OP_MEAN_LO      = 5'd8;
    localparam logic [4:0] OP_MEAN_HI      = 5'd9;
    localparam logic [4:0] OP_DARK_SCALE   = 5'd10;
    localparam logic [4:0] OP_DARK_CMP     = 5'd11;
    localparam logic [4:0] OP_BRIGHT_SCALE = 5'd12;
    localparam logic [4:0] OP_BRIGHT_CMP   = 5'd13;
    localparam logic [4:0] OP_RATIO_MIN    = 5'd14;
    localparam logic [4:0] OP_RED_SCALE    = 5'd15;
    localparam logic [4:0] OP_RATIO_MAX    = 5'd16;
    localparam logic [4:0] OP_SIZE         = 5'd17;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DRAIN = 4'b0010,
        S_CALC  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [MODE_W-1:0] mode_reg;

    logic [4:0]         op_reg;
    logic               phase_reg;
    logic [SHI_W-1:0]   rem_reg;
    logic [MEAN_W-1:0]  quot_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic               ok_lo_reg;
    logic               ok_hi_reg;
    logic               ok_dark_reg;
    logic               ok_bright_reg;
    logic               ok_rmin_reg;
    logic               ok_rmax_reg;
    logic               size_match_reg;

    logic               out_valid_reg;
    logic               passed_reg;
    logic               size_err_reg;
    logic [MEAN_W-1:0]  mean_reg;
    logic [CNT_W-1:0]   crushed_reg;
    logic [CNT_W-1:0]   clipped_reg;
    logic [CNT_W-1:0]   seen_reg;

    logic [CH_SUM_W-1:0] blue_floor;
    logic                calc_end;
    logic                result_load;
    logic                size_err;
    logic                passed;

    assign blue_floor  = (acc.blue_sum == '0) ? CH_SUM_W'(1) : acc.blue_sum;
    assign calc_end    = (state_reg == S_CALC) && phase_reg && (op_reg == OP_SIZE);
    assign result_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign acc_clear   = result_load;
    assign in_ready    = (state_reg == S_IDLE);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            mode_reg   <= MODE_CITY;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_IDX_WIDTH:  width_reg  <= cfg_data;
                CFG_IDX_HEIGHT: height_reg <= cfg_data;
                CFG_IDX_MODE:   mode_reg   <= cfg_data[MODE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pixel_take && frame_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_CALC;
            S_CALC:
            begin
                if (calc_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (result_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_DIV_FIRST;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CALC)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    op_reg <= op_reg + 1'b1;
                end
            end
            else
            begin
                op_reg    <= OP_DIV_FIRST;
                phase_reg <= 1'b0;
            end
        end
    end

    // operand select for the shared multiply-compare unit
    always_comb
    begin
        mcu_op = '0;
        case (op_reg) inside
            [OP_DIV_FIRST:OP_DIV_LAST]:
            begin
                // first step takes the dividend straight from the accumulator
                mcu_op.lhs   = (op_reg == OP_DIV_FIRST)
                             ? MP_W'(acc.luma_sum[LUMA_SUM_W-1:Q_FRAC])
                             : MP_W'(rem_reg);
                mcu_op.mul_a = MA_W'(8'h80 >> op_reg[2:0]);
                mcu_op.mul_b = MB_W'(acc.count);
            end
            OP_MEAN_LO:
            begin
                mcu_op.lhs   = MP_W'(acc.luma_sum[LUMA_SUM_W-1:Q_FRAC]);
                mcu_op.mul_a = MA_W'(mean_low(mode_reg));
                mcu_op.mul_b = MB_W'(acc.count);
            end
            OP_MEAN_HI:
            begin
                mcu_op.lhs   = MP_W'(acc.luma_sum[LUMA_SUM_W-1:Q_FRAC]);
                mcu_op.mul_a = MA_W'(mean_high(mode_reg));
                mcu_op.mul_b = MB_W'(acc.count);
            end
            OP_DARK_SCALE:
            begin
                mcu_op.mul_a = MA_W'(100);
                mcu_op.mul_b = MB_W'(acc.dark);
            end
            OP_DARK_CMP:
            begin
                mcu_op.lhs   = MP_W'(scale_reg);
                mcu_op.mul_a = MA_W'(crush_pct(mode_reg));
                mcu_op.mul_b = MB_W'(acc.count);
            end
            OP_BRIGHT_SCALE:
            begin
                mcu_op.mul_a = MA_W'(100);
                mcu_op.mul_b = MB_W'(acc.bright);
            end
            OP_BRIGHT_CMP:
            begin
                mcu_op.lhs   = MP_W'(scale_reg);
                mcu_op.mul_a = MA_W'(clip_pct(mode_reg));
                mcu_op.mul_b = MB_W'(acc.count);
            end
            OP_RATIO_MIN:
            begin
                mcu_op.lhs   = MP_W'(acc.red_sum);
                mcu_op.mul_a = MA_W'(1);
                mcu_op.mul_b = blue_floor;
            end
            OP_RED_SCALE:
            begin
                mcu_op.mul_a = MA_W'(4);
                mcu_op.mul_b = acc.red_sum;
            end
            OP_RATIO_MAX:
            begin
                mcu_op.lhs   = MP_W'(scale_reg);
                mcu_op.mul_a = MA_W'(5);
                mcu_op.mul_b = blue_floor;
            end
            OP_SIZE:
            begin
                mcu_op.lhs   = MP_W'(acc.count);
                mcu_op.mul_a = width_reg;
                mcu_op.mul_b = MB_W'(height_reg);
            end
            default: mcu_op = '0;
        endcase
    end

    // collect unit results in the cycle after issue
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DRAIN)
        begin
            quot_reg <= '0;
        end
        else if (state_reg == S_CALC && !phase_reg && op_reg == OP_DIV_FIRST)
        begin
            rem_reg <= acc.luma_sum[LUMA_SUM_W-1:Q_FRAC];
        end
        else if (state_reg == S_CALC && phase_reg)
        begin
            case (op_reg) inside
                [OP_DIV_FIRST:OP_DIV_LAST]:
                begin
                    quot_reg <= {quot_reg[MEAN_W-2:0], mcu_res.ge};
                    if (mcu_res.ge)
                    begin
                        rem_reg <= mcu_res.diff[SHI_W-1:0];
                    end
                end
                OP_MEAN_LO: ok_lo_reg <= mcu_res.ge;
                OP_MEAN_HI:
                begin
                    ok_hi_reg <= !mcu_res.ge
                              || (mcu_res.eq && acc.luma_sum[Q_FRAC-1:0] == '0);
                end
                OP_DARK_SCALE:   scale_reg <= mcu_res.prod[SCALE_W-1:0];
                OP_DARK_CMP:     ok_dark_reg <= !mcu_res.ge;
                OP_BRIGHT_SCALE: scale_reg <= mcu_res.prod[SCALE_W-1:0];
                OP_BRIGHT_CMP:   ok_bright_reg <= !mcu_res.ge;
                OP_RATIO_MIN:    ok_rmin_reg <= mcu_res.ge;
                OP_RED_SCALE:    scale_reg <= mcu_res.prod[SCALE_W-1:0];
                OP_RATIO_MAX:    ok_rmax_reg <= !mcu_res.ge || mcu_res.eq;
                OP_SIZE:         size_match_reg <= mcu_res.eq;
                default:         ;
            endcase
        end
    end

    assign size_err = (width_reg == '0) || (height_reg == '0)
                   || ({1'b0, width_reg} > MaxDim) || ({1'b0, height_reg} > MaxDim)
                   || acc.overflow || !size_match_reg;

    assign passed = !size_err && (acc.count != '0)
                 && ok_lo_reg && ok_hi_reg && ok_dark_reg && ok_bright_reg
                 && ((mode_reg != MODE_CITY) || (ok_rmin_reg && ok_rmax_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            passed_reg   <= passed;
            size_err_reg <= size_err;
            mean_reg     <= (acc.count == '0) ? '0 : quot_reg;
            crushed_reg  <= acc.dark;
            clipped_reg  <= acc.bright;
            seen_reg     <= acc.count;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_passed   = passed_reg;
    assign size_error     = size_err_reg;
    assign luma_average   = mean_reg;
    assign crushed_pixels = crushed_reg;
    assign clipped_pixels = clipped_reg;
    assign pixels_seen    = seen_reg;

    `FLEC_ASSERT_IMPLY(a_div_rem,
        (state_reg == S_DONE) && (acc.count != '0),
        rem_reg < SHI_W'(acc.count),
        "division remainder not below count")
    `FLEC_ASSERT_IMPLY(a_calc_no_take, state_reg != S_IDLE, !pixel_take,
        "pixel transfer while judging frame")

endmodule
